/* src/arc_pkg.sv */
package arc_pkg;

  localparam int ENTRIES_DEF = 16;

  localparam int OP_W     = 1;
  localparam int ADDR_W   = 8;
  localparam int MAC_W    = 48;
  localparam int PORT_W   = 8;
  localparam int STATUS_W = 3;

  // operation codes
  localparam logic [OP_W-1:0] OP_UPDATE = 1'b0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_HIT      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MISS     = 3'd4;

  // one table slot as held in the memory
  typedef struct packed {
    logic [ADDR_W-1:0] net_addr;
    logic [MAC_W-1:0]  mac;
    logic [PORT_W-1:0] port;
  } entry_t;

endpackage

/* src/arc_if.sv */
interface arc_req_if;
  logic                       valid;
  logic                       ready;
  logic [arc_pkg::OP_W-1:0]   op;
  logic [arc_pkg::ADDR_W-1:0] net_addr;
  logic [arc_pkg::MAC_W-1:0]  mac_addr;
  logic [arc_pkg::PORT_W-1:0] port_index;

  modport source (output valid, op, net_addr, mac_addr, port_index, input ready);
  modport sink   (input valid, op, net_addr, mac_addr, port_index, output ready);
endinterface

interface arc_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [arc_pkg::STATUS_W-1:0] status;
  logic [arc_pkg::MAC_W-1:0]    found_mac;
  logic [arc_pkg::PORT_W-1:0]   found_port;

  modport source (output valid, status, found_mac, found_port, input ready);
  modport sink   (input valid, status, found_mac, found_port, output ready);
endinterface

/* src/address_resolution_cache_core.sv */
// Channel  Dir  Payload                                   Word accepted when
// req      in   op, net_addr, mac_addr, port_index        req.valid && req.ready
// rsp      out  status, found_mac, found_port             rsp.valid && rsp.ready
//
// Scan: after a word is accepted, each slot scanned takes a memory read,
//   then a compare; a match ends the scan early. The registered read of the
//   table memory splits each slot into these two steps.
// Reset: rst clears the valid flags at once; no clearing pass is needed.
// Stalls: the result sits in an output register; a new word is taken while it
//   waits. A scan that ends while the register is still full holds in place.
module address_resolution_cache_core #(
  parameter int ENTRIES = arc_pkg::ENTRIES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  arc_req_if.sink       req,
  arc_rsp_if.source     rsp
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CMP
  } state_t;

  state_t state;

  // latched request
  logic [arc_pkg::OP_W-1:0]   cur_op;
  logic [arc_pkg::ADDR_W-1:0] cur_addr;
  logic [arc_pkg::MAC_W-1:0]  cur_mac;
  logic [arc_pkg::PORT_W-1:0] cur_port;

  // scan pointer and first free slot seen so far
  logic [IDX_W-1:0] idx;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;

  logic [ENTRIES-1:0] valid;

  // table memory, one read port (registered), one write port
  arc_pkg::entry_t mem [ENTRIES];
  arc_pkg::entry_t rd_data;
  arc_pkg::entry_t wr_data;
  logic            mem_we;
  logic [IDX_W-1:0] mem_wa;

  // output register
  logic                         rsp_valid;
  logic [arc_pkg::STATUS_W-1:0] rsp_status;
  logic [arc_pkg::MAC_W-1:0]    rsp_mac;
  logic [arc_pkg::PORT_W-1:0]   rsp_port;

  logic             hit;
  logic             last;
  logic             done;
  logic             out_free;
  logic             issue;
  logic             ins_ok;
  logic [IDX_W-1:0] ins_idx;

  assign hit      = valid[idx] && (rd_data.net_addr == cur_addr);
  assign last     = (idx == LAST_IDX);
  assign done     = hit || last;
  assign out_free = !rsp_valid || rsp.ready;
  // scan finished and the output register can take the result
  assign issue    = (state == S_CMP) && done && out_free;
  // free slot: an earlier one, else the slot under compare
  assign ins_ok   = free_found || !valid[idx];
  assign ins_idx  = free_found ? free_idx : idx;

  assign mem_we  = issue && (cur_op == arc_pkg::OP_UPDATE) && (hit || ins_ok);
  assign mem_wa  = hit ? idx : ins_idx;
  assign wr_data = '{net_addr: cur_addr, mac: cur_mac, port: cur_port};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= wr_data;
    end
    rd_data <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      valid      <= '0;
      rsp_valid  <= 1'b0;
      idx        <= '0;
      free_found <= 1'b0;
    end else begin
      if (issue) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            cur_op     <= req.op;
            cur_addr   <= req.net_addr;
            cur_mac    <= req.mac_addr;
            cur_port   <= req.port_index;
            idx        <= '0;
            free_found <= 1'b0;
            state      <= S_READ;
          end
        end
        S_READ: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (done) begin
            if (out_free) begin
              state <= S_IDLE;
              if (cur_op == arc_pkg::OP_LOOKUP) begin
                if (hit) begin
                  rsp_status <= arc_pkg::ST_HIT;
                  rsp_mac    <= rd_data.mac;
                  rsp_port   <= rd_data.port;
                end else begin
                  rsp_status <= arc_pkg::ST_MISS;
                  rsp_mac    <= '0;
                  rsp_port   <= '0;
                end
              end else begin
                rsp_mac  <= '0;
                rsp_port <= '0;
                if (hit) begin
                  rsp_status <= arc_pkg::ST_UPDATED;
                end else if (ins_ok) begin
                  rsp_status       <= arc_pkg::ST_INSERTED;
                  valid[ins_idx]   <= 1'b1;
                end else begin
                  rsp_status <= arc_pkg::ST_FULL;
                end
              end
            end
          end else begin
            if (!free_found && !valid[idx]) begin
              free_found <= 1'b1;
              free_idx   <= idx;
            end
            idx   <= idx + IDX_W'(1);
            state <= S_READ;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req.ready      = (state == S_IDLE);
  assign rsp.valid      = rsp_valid;
  assign rsp.status     = rsp_status;
  assign rsp.found_mac  = rsp_mac;
  assign rsp.found_port = rsp_port;

endmodule

/* src/arc_checker.sv */
module arc_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [arc_pkg::STATUS_W-1:0] status,
  input logic [arc_pkg::MAC_W-1:0]    found_mac,
  input logic [arc_pkg::PORT_W-1:0]   found_port
);

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(found_mac)
      && $stable(found_port))
    else $error("stalled result changed");

  // only defined status codes
  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> status <= arc_pkg::ST_MISS)
    else $error("undefined status code");

  // data fields are zero unless a lookup hit
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != arc_pkg::ST_HIT |-> found_mac == '0 && found_port == '0)
    else $error("nonzero data on non-hit result");

  // a taken word keeps the block busy for the scan
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("ready right after accept");

  // nothing pending out of reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

endmodule

bind address_resolution_cache_core arc_checker u_arc_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .status     (rsp.status),
  .found_mac  (rsp.found_mac),
  .found_port (rsp.found_port)
);

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  localparam int TABLE_DEPTH = arc_pkg::ENTRIES_DEF;
  // drain past the longest possible scan at the end
  localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 8;
  // cycles with no accepted word on either side before giving up
  localparam int STALL_LIMIT = 3000;
  localparam int RANDOM_WORDS = 1100;
  localparam int POOL_SIZE = 24;

  typedef logic [arc_pkg::OP_W-1:0]     op_t;
  typedef logic [arc_pkg::ADDR_W-1:0]   addr_t;
  typedef logic [arc_pkg::MAC_W-1:0]    mac_t;
  typedef logic [arc_pkg::PORT_W-1:0]   port_t;
  typedef logic [arc_pkg::STATUS_W-1:0] status_t;

  // request word as queued for the driver
  typedef struct {
    op_t   op;
    addr_t net_addr;
    mac_t  mac_addr;
    port_t port_index;
  } req_word_t;

  // expected response word
  typedef struct {
    status_t status;
    mac_t    found_mac;
    port_t   found_port;
  } rsp_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  arc_req_if req_if ();
  arc_rsp_if rsp_if ();

  address_resolution_cache_core #(
    .ENTRIES(TABLE_DEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  // 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the resolution table. Slot data is only ever read while the
  // slot's valid flag is set, so the data arrays need no reset.
  // ---------------------------------------------------------------------------
  logic  shadow_valid [TABLE_DEPTH];
  addr_t shadow_addr  [TABLE_DEPTH];
  mac_t  shadow_mac   [TABLE_DEPTH];
  port_t shadow_port  [TABLE_DEPTH];

  req_word_t pending_words[$];   // words not yet driven
  rsp_word_t resolutions[$];     // expected responses, oldest first

  int errors = 0;
  int words_sent = 0;
  int status_seen [8];
  int idle_cycles = 0;

  logic req_fire = 1'b0;
  logic rsp_fire = 1'b0;
  int   req_gap = 0;
  int   req_burst = 0;
  int   rsp_gap = 0;
  int   rsp_burst = 0;
  req_word_t drive_word;

  // Apply one word to the shadow table and return the response it must give.
  // Match first (lowest slot wins), then lowest free slot, else drop as full.
  function automatic rsp_word_t resolve_word(req_word_t w);
    rsp_word_t res;
    int hit_slot;
    int free_slot;
    hit_slot = -1;
    free_slot = -1;
    res.status = arc_pkg::ST_MISS;
    res.found_mac = '0;
    res.found_port = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (shadow_valid[i] && shadow_addr[i] == w.net_addr) hit_slot = i;
      if (!shadow_valid[i]) free_slot = i;
    end
    if (w.op == arc_pkg::OP_LOOKUP) begin
      if (hit_slot >= 0) begin
        res.status = arc_pkg::ST_HIT;
        res.found_mac = shadow_mac[hit_slot];
        res.found_port = shadow_port[hit_slot];
      end
    end else if (hit_slot >= 0) begin
      shadow_mac[hit_slot] = w.mac_addr;
      shadow_port[hit_slot] = w.port_index;
      res.status = arc_pkg::ST_UPDATED;
    end else if (free_slot >= 0) begin
      shadow_valid[free_slot] = 1'b1;
      shadow_addr[free_slot] = w.net_addr;
      shadow_mac[free_slot] = w.mac_addr;
      shadow_port[free_slot] = w.port_index;
      res.status = arc_pkg::ST_INSERTED;
    end else begin
      res.status = arc_pkg::ST_FULL;
    end
    return res;
  endfunction

  // Idle length between words: mostly none, some short, a few long. Now and
  // then a burst starts in which no idling happens at all.
  function automatic int pick_gap(inout int burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if (r < 2) begin
      burst = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void queue_word(op_t op, addr_t addr, mac_t mac, port_t port);
    req_word_t w;
    w.op = op;
    w.net_addr = addr;
    w.mac_addr = mac;
    w.port_index = port;
    pending_words.push_back(w);
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: changes inputs on the falling edge. A word is held until
  // the rising edge that accepts it (req_fire), then the next one follows
  // after a random gap.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_fire) begin
      if (req_gap > 0) begin
        req_gap--;
        req_if.valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        drive_word = pending_words.pop_front();
        req_if.op <= drive_word.op;
        req_if.net_addr <= drive_word.net_addr;
        req_if.mac_addr <= drive_word.mac_addr;
        req_if.port_index <= drive_word.port_index;
        req_if.valid <= 1'b1;
        req_gap = pick_gap(req_burst);
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Response back-pressure: a stall may follow each accepted result, and a
  // few start at random, so they can overlap a running scan.
  always @(negedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_fire || (rsp_gap == 0 && $urandom_range(0, 15) == 0))
        rsp_gap = pick_gap(rsp_burst);
      if (rsp_gap > 0) begin
        rsp_gap--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: samples both channels on the rising edge. The response check
  // runs before the prediction for a word accepted on the same edge, since a
  // result can only belong to an older word.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    rsp_word_t want;
    req_word_t got_req;
    req_fire <= !rst && req_if.valid && req_if.ready;
    rsp_fire <= !rst && rsp_if.valid && rsp_if.ready;
    if (!rst) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (resolutions.size() == 0) begin
          $error("response word with nothing outstanding: status %0d", rsp_if.status);
          errors++;
        end else begin
          want = resolutions.pop_front();
          if (rsp_if.status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, rsp_if.status);
            errors++;
          end
          if (rsp_if.found_mac !== want.found_mac) begin
            $error("found_mac mismatch: expected %h, got %h",
                   want.found_mac, rsp_if.found_mac);
            errors++;
          end
          if (rsp_if.found_port !== want.found_port) begin
            $error("found_port mismatch: expected %0d, got %0d",
                   want.found_port, rsp_if.found_port);
            errors++;
          end
          status_seen[want.status]++;
        end
      end
      if (req_if.valid && req_if.ready) begin
        got_req.op = req_if.op;
        got_req.net_addr = req_if.net_addr;
        got_req.mac_addr = req_if.mac_addr;
        got_req.port_index = req_if.port_index;
        resolutions.push_back(resolve_word(got_req));
        words_sent++;
      end
    end
  end

  // Watchdog: ends the run if neither channel moves a word for too long.
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
      $display("address_resolution_cache_core verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    addr_t addr_pool [POOL_SIZE];
    addr_t addr;
    op_t   op;

    req_if.valid = 1'b0;
    req_if.op = arc_pkg::OP_UPDATE;
    req_if.net_addr = '0;
    req_if.mac_addr = '0;
    req_if.port_index = '0;
    rsp_if.ready = 1'b0;
    for (int i = 0; i < TABLE_DEPTH; i++) shadow_valid[i] = 1'b0;
    for (int i = 0; i < 8; i++) status_seen[i] = 0;

    // Directed: miss on an empty table (with junk in the ignored fields),
    // inserts and rewrites at the address extremes, hits returning all-ones
    // and all-zero data, and a miss on an address never stored.
    queue_word(arc_pkg::OP_LOOKUP, 8'h00, '1, '1);
    queue_word(arc_pkg::OP_UPDATE, 8'h00, '1, '1);
    queue_word(arc_pkg::OP_UPDATE, 8'hFF, '0, '0);
    queue_word(arc_pkg::OP_LOOKUP, 8'h00, '0, '0);
    queue_word(arc_pkg::OP_LOOKUP, 8'hFF, '1, '1);
    queue_word(arc_pkg::OP_UPDATE, 8'h00, 48'h5555_5555_5555, 8'hAA);
    queue_word(arc_pkg::OP_UPDATE, 8'hFF, 48'hAAAA_AAAA_AAAA, 8'h55);
    queue_word(arc_pkg::OP_LOOKUP, 8'h00, 48'h0123_4567_89AB, 8'h12);
    queue_word(arc_pkg::OP_LOOKUP, 8'hFF, '0, '0);
    queue_word(arc_pkg::OP_LOOKUP, 8'h80, '0, '0);
    queue_word(arc_pkg::OP_UPDATE, 8'h80, 48'h8000_0000_0001, 8'h80);
    queue_word(arc_pkg::OP_LOOKUP, 8'h80, '0, '0);
    queue_word(arc_pkg::OP_LOOKUP, 8'h7F, '1, '1);

    // Random: most addresses come from a small pool so the table fills early,
    // updates hit existing slots, drops on a full table show up, and lookups
    // split between hits and misses. The rest are fully random addresses.
    addr_pool[0] = 8'h00;
    addr_pool[1] = 8'hFF;
    for (int i = 2; i < POOL_SIZE; i++) addr_pool[i] = addr_t'($urandom_range(0, 255));
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if ($urandom_range(0, 9) == 0)
        addr = addr_t'($urandom_range(0, 255));
      else
        addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
      op = ($urandom_range(0, 1) == 0) ? arc_pkg::OP_UPDATE : arc_pkg::OP_LOOKUP;
      queue_word(op, addr, mac_t'({$urandom, $urandom}), port_t'($urandom_range(0, 255)));
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // all words out, accepted, and answered
    while (pending_words.size() != 0 || req_if.valid || resolutions.size() != 0)
      @(negedge clk);
    // catch any stray extra response
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d request words: %0d inserted, %0d updated, %0d dropped on a full table",
             words_sent, status_seen[arc_pkg::ST_INSERTED],
             status_seen[arc_pkg::ST_UPDATED], status_seen[arc_pkg::ST_FULL]);
    $display("lookups: %0d hits, %0d misses", status_seen[arc_pkg::ST_HIT],
             status_seen[arc_pkg::ST_MISS]);
    if (errors == 0)
      $display("address_resolution_cache_core verification clean");
    else
      $display("address_resolution_cache_core verification failed");
    $finish;
  end

endmodule

/* address_resolution_cache_core.f */
src/arc_pkg.sv
src/arc_if.sv
src/address_resolution_cache_core.sv
src/arc_checker.sv
dv/tb_top.sv
